@@ sv/dag_path_counter_assert.svh @@
// ----------------------------------------------------------------------------
// dag_path_counter_assert
// Assertion macros used by dag_path_counter.
// ----------------------------------------------------------------------------
`ifndef DAG_PATH_COUNTER_ASSERT_SVH
`define DAG_PATH_COUNTER_ASSERT_SVH

// Invariant that holds at every clock edge out of reset.
`define DPC_CHECK(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant failed");

// Condition in one cycle implies a consequence in the next.
`define DPC_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence check failed");

`endif

@@ sv/dpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dpc_pkg
// Widths and constants of the path counter.
// ----------------------------------------------------------------------------
package dpc_pkg;
    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NODE_W    = $clog2(MAX_NODES);      // node index 0..n-1
    localparam int EADDR_W   = $clog2(MAX_EDGES);      // edge store address
    localparam int ECNT_W    = $clog2(MAX_EDGES) + 1;  // 0..MAX_EDGES
    localparam int FIELD_W   = 11;                     // node id field width
    localparam int PATH_W    = 30;
    localparam logic [PATH_W-1:0] PATH_MOD = 30'd1000000007;
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_RUN = 1'b1;
endpackage

@@ sv/dpc_if.sv @@
// ----------------------------------------------------------------------------
// dpc_if
// Valid/ready channels of the path counter: requests, results, configuration.
// ----------------------------------------------------------------------------
interface dpc_req_if import dpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               func;
    logic [FIELD_W-1:0] edge_from;
    logic [FIELD_W-1:0] edge_to;
    modport source (output valid, func, edge_from, edge_to, input ready);
    modport sink   (input valid, func, edge_from, edge_to, output ready);
endinterface

interface dpc_rsp_if import dpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PATH_W-1:0] path_count;
    logic              has_cycle;
    logic              edges_dropped;
    modport source (output valid, path_count, has_cycle, edges_dropped, input ready);
    modport sink   (input valid, path_count, has_cycle, edges_dropped, output ready);
endinterface

interface dpc_cfg_if import dpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ sv/dpc_ram.sv @@
// ----------------------------------------------------------------------------
// dpc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dpc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/dag_path_counter.sv @@
// ----------------------------------------------------------------------------
// dag_path_counter
// Counts paths from node 1 to the last node of a loaded graph, mod 1000000007,
// using a Kahn topological sort over memory-held adjacency lists.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                                   | accepted when
//  i_req    | in  | func, edge_from, edge_to                 | valid & ready
//  o_rsp    | out | path_count, has_cycle, edges_dropped     | valid & ready
//  i_cfg    | in  | data (node_count)                        | valid & ready
//
//  An add request writes the edge store as it is taken. A run request clears
//  the node tables, counts and places edges, seeds the queue, runs a Kahn pass;
//  on an acyclic graph a path-sum pass follows, while a cycle ends the run
//  after the Kahn pass. Every pass walks one node or one edge at a time.
//  Reset clears control state only; the node tables are rebuilt by each run.
//  Add requests are taken while a result waits; a run stalls at its end
//  until the result register is free.
// ----------------------------------------------------------------------------
`include "dag_path_counter_assert.svh"

module dag_path_counter import dpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dpc_req_if.sink   i_req,
    dpc_rsp_if.source o_rsp,
    dpc_cfg_if.sink   i_cfg
);
    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;   // clear node tables
    localparam logic [3:0] S_ERD  = 4'd2;   // edge pass: read edge
    localparam logic [3:0] S_ECHK = 4'd3;   // edge pass: check, read tables
    localparam logic [3:0] S_EWR  = 4'd4;   // edge pass: write back
    localparam logic [3:0] S_PRD  = 4'd5;   // prefix: read count
    localparam logic [3:0] S_PWR  = 4'd6;   // prefix: write start
    localparam logic [3:0] S_QRD  = 4'd7;   // seed queue: read degree
    localparam logic [3:0] S_QCHK = 4'd8;   // seed queue: push zero degree
    localparam logic [3:0] S_POP  = 4'd9;   // pop queue head
    localparam logic [3:0] S_TU   = 4'd10;  // read node tables for u
    localparam logic [3:0] S_TSE  = 4'd11;  // capture edge range of u
    localparam logic [3:0] S_TE   = 4'd12;  // next edge of u
    localparam logic [3:0] S_TV   = 4'd13;  // read tables for v
    localparam logic [3:0] S_TW   = 4'd14;  // write back v
    localparam logic [3:0] S_DONE = 4'd15;  // hand over result

    logic [3:0]         r_state, n_state;
    logic [FIELD_W-1:0] r_node_cfg;
    logic [FIELD_W-1:0] r_n, n_n;
    logic [ECNT_W-1:0]  r_loaded, n_loaded;
    logic               r_drop, n_drop;
    logic [ECNT_W-1:0]  r_idx, n_idx;
    logic [ECNT_W-1:0]  r_acc, n_acc;
    logic               r_fill, n_fill;     // edge pass: 0 count, 1 fill
    logic               r_paths, n_paths;   // traversal: 0 Kahn, 1 path sums
    logic [FIELD_W-1:0] r_head, n_head;
    logic [FIELD_W-1:0] r_tail, n_tail;
    logic [NODE_W-1:0]  r_a, n_a;
    logic [NODE_W-1:0]  r_b, n_b;
    logic [ECNT_W-1:0]  r_i, n_i;
    logic [ECNT_W-1:0]  r_end, n_end;
    logic [PATH_W-1:0]  r_pu, n_pu;
    logic               r_cycle, n_cycle;
    logic [PATH_W-1:0]  r_res, n_res;
    logic               r_out_valid;
    logic [PATH_W-1:0]  r_out_count;
    logic               r_out_cycle;
    logic               r_out_drop;

    // RAM ports
    logic               es_we, ed_we, adj_we, deg_we, cnt_we, st_we, path_we, q_we;
    logic [EADDR_W-1:0] es_wa, adj_wa, adj_ra;
    logic [NODE_W-1:0]  deg_wa, deg_ra, cnt_wa, cnt_ra, st_wa, st_ra;
    logic [NODE_W-1:0]  path_wa, path_ra, q_wa, q_ra;
    logic [NODE_W-1:0]  es_wd, ed_wd, adj_wd, q_wd;
    logic [ECNT_W-1:0]  deg_wd, cnt_wd, st_wd;
    logic [PATH_W-1:0]  path_wd;
    logic [NODE_W-1:0]  es_rd, ed_rd, adj_rd, q_rd;
    logic [ECNT_W-1:0]  deg_rd, cnt_rd, st_rd;
    logic [PATH_W-1:0]  path_rd;

    dpc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_src (
        .i_clk(i_clk), .i_we(es_we), .i_waddr(es_wa), .i_wdata(es_wd),
        .i_raddr(r_idx[EADDR_W-1:0]), .o_rdata(es_rd));
    dpc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_dst (
        .i_clk(i_clk), .i_we(ed_we), .i_waddr(es_wa), .i_wdata(ed_wd),
        .i_raddr(r_idx[EADDR_W-1:0]), .o_rdata(ed_rd));
    dpc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_wa), .i_wdata(adj_wd),
        .i_raddr(adj_ra), .o_rdata(adj_rd));
    dpc_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_NODES)) u_deg (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_wa), .i_wdata(deg_wd),
        .i_raddr(deg_ra), .o_rdata(deg_rd));
    dpc_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_NODES)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_wa), .i_wdata(cnt_wd),
        .i_raddr(cnt_ra), .o_rdata(cnt_rd));
    dpc_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_NODES)) u_start (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd));
    dpc_ram #(.WIDTH(PATH_W), .DEPTH(MAX_NODES)) u_path (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_wa), .i_wdata(path_wd),
        .i_raddr(path_ra), .o_rdata(path_rd));
    dpc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(q_ra), .o_rdata(q_rd));

    // effective node count: zero acts as one, above capacity clamps
    logic [FIELD_W-1:0] w_n_eff;
    always_comb begin
        if (r_node_cfg == '0) begin
            w_n_eff = FIELD_W'(1);
        end else if (r_node_cfg > FIELD_W'(MAX_NODES)) begin
            w_n_eff = FIELD_W'(MAX_NODES);
        end else begin
            w_n_eff = r_node_cfg;
        end
    end

    logic [FIELD_W-1:0] w_last;
    logic               w_out_free;
    logic               w_req_take;
    logic               w_add_ok;
    logic [ECNT_W-1:0]  w_deg_dec;
    logic [PATH_W:0]    w_sum;
    logic [PATH_W:0]    w_sum_red;

    assign w_last     = r_n - FIELD_W'(1);
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_req_take = i_req.valid && i_req.ready;
    assign w_add_ok   = (i_req.edge_from != '0) && (i_req.edge_from <= w_n_eff) &&
                        (i_req.edge_to != '0) && (i_req.edge_to <= w_n_eff) &&
                        (r_loaded < ECNT_W'(MAX_EDGES));
    assign w_deg_dec  = deg_rd - ECNT_W'(1);
    assign w_sum      = {1'b0, path_rd} + {1'b0, r_pu};
    assign w_sum_red  = (w_sum >= {1'b0, PATH_MOD}) ? (w_sum - {1'b0, PATH_MOD}) : w_sum;

    always_comb begin
        n_state = r_state;  n_n = r_n;  n_loaded = r_loaded;  n_drop = r_drop;
        n_idx = r_idx;  n_acc = r_acc;  n_fill = r_fill;  n_paths = r_paths;
        n_head = r_head;  n_tail = r_tail;  n_a = r_a;  n_b = r_b;
        n_i = r_i;  n_end = r_end;  n_pu = r_pu;  n_cycle = r_cycle;  n_res = r_res;

        es_we = 1'b0;  ed_we = 1'b0;  es_wa = r_loaded[EADDR_W-1:0];
        es_wd = NODE_W'(i_req.edge_from - FIELD_W'(1));
        ed_wd = NODE_W'(i_req.edge_to - FIELD_W'(1));
        adj_we = 1'b0;  adj_wa = cnt_rd[EADDR_W-1:0];  adj_wd = r_b;
        adj_ra = r_i[EADDR_W-1:0];
        deg_we = 1'b0;  deg_wa = r_idx[NODE_W-1:0];  deg_wd = '0;
        deg_ra = r_idx[NODE_W-1:0];
        cnt_we = 1'b0;  cnt_wa = r_idx[NODE_W-1:0];  cnt_wd = '0;
        cnt_ra = r_idx[NODE_W-1:0];
        st_we = 1'b0;  st_wa = r_idx[NODE_W-1:0];  st_wd = r_acc;
        st_ra = q_rd;
        path_we = 1'b0;  path_wa = r_idx[NODE_W-1:0];  path_wd = '0;
        path_ra = q_rd;
        q_we = 1'b0;  q_wa = r_tail[NODE_W-1:0];  q_wd = r_idx[NODE_W-1:0];
        q_ra = r_head[NODE_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_req_take) begin
                    if (i_req.func == FUNC_ADD) begin
                        if (w_add_ok) begin
                            es_we = 1'b1;
                            ed_we = 1'b1;
                            n_loaded = r_loaded + ECNT_W'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else begin
                        n_n = w_n_eff;
                        n_idx = '0;
                        n_state = S_CLR;
                    end
                end
            end
            S_CLR: begin
                // clear node tables; node 1 starts with one path
                deg_we = 1'b1;
                cnt_we = 1'b1;
                path_we = 1'b1;
                path_wd = (r_idx == '0) ? PATH_W'(1) : '0;
                if (r_idx == ECNT_W'(w_last)) begin
                    n_idx = '0;
                    n_fill = 1'b0;
                    n_state = S_ERD;
                end else begin
                    n_idx = r_idx + ECNT_W'(1);
                end
            end
            S_ERD: begin
                if (r_idx == r_loaded) begin
                    n_idx = '0;
                    n_acc = '0;
                    n_state = r_fill ? S_QRD : S_PRD;
                end else begin
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                n_a = es_rd;
                n_b = ed_rd;
                cnt_ra = es_rd;
                deg_ra = ed_rd;
                if ((FIELD_W'(es_rd) >= r_n) || (FIELD_W'(ed_rd) >= r_n)) begin
                    // node count lowered after loading: skip the edge
                    n_drop = 1'b1;
                    n_idx = r_idx + ECNT_W'(1);
                    n_state = S_ERD;
                end else begin
                    n_state = S_EWR;
                end
            end
            S_EWR: begin
                cnt_we = 1'b1;
                cnt_wa = r_a;
                cnt_wd = cnt_rd + ECNT_W'(1);
                if (r_fill) begin
                    adj_we = 1'b1;
                end else begin
                    deg_we = 1'b1;
                    deg_wa = r_b;
                    deg_wd = deg_rd + ECNT_W'(1);
                end
                n_idx = r_idx + ECNT_W'(1);
                n_state = S_ERD;
            end
            S_PRD: begin
                n_state = S_PWR;
            end
            S_PWR: begin
                // start and fill pointer both get the running sum
                st_we = 1'b1;
                cnt_we = 1'b1;
                cnt_wd = r_acc;
                n_acc = r_acc + cnt_rd;
                if (r_idx == ECNT_W'(w_last)) begin
                    n_idx = '0;
                    n_fill = 1'b1;
                    n_state = S_ERD;
                end else begin
                    n_idx = r_idx + ECNT_W'(1);
                    n_state = S_PRD;
                end
            end
            S_QRD: begin
                n_state = S_QCHK;
            end
            S_QCHK: begin
                if (deg_rd == '0) begin
                    q_we = 1'b1;
                    n_tail = r_tail + FIELD_W'(1);
                end
                if (r_idx == ECNT_W'(w_last)) begin
                    n_paths = 1'b0;
                    n_state = S_POP;
                end else begin
                    n_idx = r_idx + ECNT_W'(1);
                    n_state = S_QRD;
                end
            end
            S_POP: begin
                if (r_head == r_tail) begin
                    if (r_paths) begin
                        n_idx = ECNT_W'(w_last);
                        n_state = S_TU;
                    end else if (r_tail < r_n) begin
                        n_cycle = 1'b1;
                        n_res = (r_n == FIELD_W'(1)) ? PATH_W'(1) : '0;
                        n_state = S_DONE;
                    end else begin
                        n_cycle = 1'b0;
                        n_paths = 1'b1;
                        n_head = '0;
                    end
                end else begin
                    n_head = r_head + FIELD_W'(1);
                    n_state = S_TU;
                end
            end
            S_TU: begin
                if (r_paths && (r_head == r_tail)) begin
                    // traversal done: fetch the target's sum
                    path_ra = w_last[NODE_W-1:0];
                    n_state = S_TSE;
                end else begin
                    cnt_ra = q_rd;
                    n_state = S_TSE;
                end
            end
            S_TSE: begin
                if (r_paths && (r_head == r_tail) && (r_idx == ECNT_W'(w_last))) begin
                    n_res = path_rd;
                    n_state = S_DONE;
                end else begin
                    n_i = st_rd;
                    n_end = cnt_rd;
                    n_pu = path_rd;
                    n_state = S_TE;
                end
            end
            S_TE: begin
                n_state = (r_i == r_end) ? S_POP : S_TV;
            end
            S_TV: begin
                n_b = adj_rd;
                deg_ra = adj_rd;
                path_ra = adj_rd;
                n_state = S_TW;
            end
            S_TW: begin
                if (r_paths) begin
                    path_we = 1'b1;
                    path_wa = r_b;
                    path_wd = w_sum_red[PATH_W-1:0];
                end else begin
                    deg_we = 1'b1;
                    deg_wa = r_b;
                    deg_wd = w_deg_dec;
                    if (w_deg_dec == '0) begin
                        q_we = 1'b1;
                        q_wd = r_b;
                        n_tail = r_tail + FIELD_W'(1);
                    end
                end
                n_i = r_i + ECNT_W'(1);
                n_state = S_TE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_loaded = '0;
                    n_drop = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_state == S_IDLE && w_req_take && i_req.func == FUNC_RUN) begin
            n_head = '0;
            n_tail = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_node_cfg <= FIELD_W'(1);
            r_n <= FIELD_W'(1);
            r_loaded <= '0;
            r_drop <= 1'b0;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= 1'b0;
            r_paths <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n <= n_n;
            r_loaded <= n_loaded;
            r_drop <= n_drop;
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
            r_paths <= n_paths;
            if (i_cfg.valid && i_cfg.ready) begin
                r_node_cfg <= i_cfg.data;
            end
            // load the result register when the run ends, else drop it once taken
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_acc <= n_acc;
        r_a <= n_a;
        r_b <= n_b;
        r_i <= n_i;
        r_end <= n_end;
        r_pu <= n_pu;
        r_cycle <= n_cycle;
        r_res <= n_res;
        if (r_state == S_DONE && w_out_free) begin
            r_out_count <= r_res;
            r_out_cycle <= r_cycle;
            r_out_drop <= r_drop;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.path_count = r_out_count;
    assign o_rsp.has_cycle = r_out_cycle;
    assign o_rsp.edges_dropped = r_out_drop;

    `DPC_CHECK(a_tail_le_n, i_clk, i_rst_n, r_tail <= r_n)
    `DPC_CHECK(a_head_le_tail, i_clk, i_rst_n, r_head <= r_tail)
    `DPC_CHECK(a_loaded_cap, i_clk, i_rst_n, r_loaded <= ECNT_W'(MAX_EDGES))
    `DPC_NEXT(a_done_shows, i_clk, i_rst_n, (r_state == S_DONE) && w_out_free,
              o_rsp.valid && (r_state == S_IDLE) && (r_loaded == '0))
endmodule
